@@ rtl/core/htfd_pkg.sv @@
// shared types and constants for the humidity and temperature frame decoder
`default_nettype none
package htfd_pkg;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  localparam logic [2:0] PosTempHi = 3'd0;
  localparam logic [2:0] PosTempLo = 3'd1;
  localparam logic [2:0] PosTempCrc = 3'd2;
  localparam logic [2:0] PosHumHi = 3'd3;
  localparam logic [2:0] PosHumLo = 3'd4;
  localparam logic [2:0] PosHumCrc = 3'd5;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusTempCrc = 2'd1;
  localparam logic [1:0] StatusHumCrc = 2'd2;

  localparam logic [10:0] TempScale = 11'd1750;
  localparam logic [9:0] HumScale = 10'd1000;
  localparam logic [11:0] TempOffset = 12'd450;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [9:0]         humidity_tenths;
    logic [1:0]         frame_status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] temperature_word;
    logic [15:0] humidity_word;
    logic [1:0]  frame_status;
  } job_t;

endpackage
`default_nettype wire

@@ rtl/core/htfd_front.sv @@
// byte intake: frame position, crc check and word assembly
`default_nettype none
module htfd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  htfd_pkg::in_item_t    in_data_i,
  output logic                  push_o,
  output htfd_pkg::job_t        job_o,
  input  wire logic             full_i
);

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ htfd_pkg::CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [2:0]  pos_q, pos_d, pos;
  logic [7:0]  crc_q, crc_d, crc_in;
  logic [15:0] tword_q, tword_d;
  logic [15:0] hword_q, hword_d;
  logic        tgood_q, tgood_d;
  logic        accept;
  logic [7:0]  b;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.frame_byte;

  always_comb begin
    pos     = (in_data_i.frame_start || pos_q > htfd_pkg::PosHumCrc) ?
              htfd_pkg::PosTempHi : pos_q;
    crc_in  = (pos == htfd_pkg::PosTempHi || pos == htfd_pkg::PosHumHi) ?
              htfd_pkg::CrcInit : crc_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    tword_d = tword_q;
    hword_d = hword_q;
    tgood_d = tgood_q;
    push_o  = 1'b0;
    job_o.temperature_word = tword_q;
    job_o.humidity_word    = hword_q;
    if (!tgood_q) begin
      job_o.frame_status = htfd_pkg::StatusTempCrc;
    end else if (crc_q != b) begin
      job_o.frame_status = htfd_pkg::StatusHumCrc;
    end else begin
      job_o.frame_status = htfd_pkg::StatusOk;
    end
    if (accept) begin
      pos_d = pos + 3'd1;
      case (pos)
        htfd_pkg::PosTempHi: begin
          crc_d   = crc8_feed(crc_in, b);
          tword_d = {b, tword_q[7:0]};
        end
        htfd_pkg::PosTempLo: begin
          crc_d   = crc8_feed(crc_in, b);
          tword_d = {tword_q[15:8], b};
        end
        htfd_pkg::PosTempCrc: begin
          tgood_d = (crc_q == b);
          crc_d   = htfd_pkg::CrcInit;
        end
        htfd_pkg::PosHumHi: begin
          crc_d   = crc8_feed(crc_in, b);
          hword_d = {b, hword_q[7:0]};
        end
        htfd_pkg::PosHumLo: begin
          crc_d   = crc8_feed(crc_in, b);
          hword_d = {hword_q[15:8], b};
        end
        default: begin
          crc_d  = htfd_pkg::CrcInit;
          pos_d  = htfd_pkg::PosTempHi;
          push_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= htfd_pkg::PosTempHi;
      crc_q   <= htfd_pkg::CrcInit;
      tword_q <= '0;
      hword_q <= '0;
      tgood_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      tword_q <= tword_d;
      hword_q <= hword_d;
      tgood_q <= tgood_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/htfd_fifo.sv @@
// two-entry job queue between front and back
`default_nettype none
module htfd_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  htfd_pkg::job_t push_data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output htfd_pkg::job_t pop_data_o,
  output logic           empty_o
);

  htfd_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/htfd_back.sv @@
// conversion pipeline: scale products, rounded division by full scale, output register
`default_nettype none
module htfd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  htfd_pkg::job_t       job_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output htfd_pkg::out_item_t  out_data_o
);

  // nearest integer to x / 65535, x below 2^27
  function automatic logic [11:0] div_fs_round(input logic [26:0] x);
    logic [28:0] z;
    logic [28:0] s;
    z = {2'b0, x} + 29'd32767;
    s = z + {16'b0, z[28:16]} + 29'd1;
    return s[27:16];
  endfunction

  logic        s1_valid_q;
  logic [26:0] tprod_q;
  logic [25:0] hprod_q;
  logic [1:0]  s1_status_q;
  logic        out_valid_q;
  htfd_pkg::out_item_t out_q;
  logic        out_free, s1_move;
  logic [11:0] tq;
  logic [11:0] hq;

  assign out_free    = !out_valid_q || out_ready_i;
  assign s1_move     = s1_valid_q && out_free;
  assign pop_o       = !empty_i && (!s1_valid_q || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign tq = div_fs_round(tprod_q);
  assign hq = div_fs_round({1'b0, hprod_q});

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tprod_q     <= 27'(job_i.temperature_word) * 27'(htfd_pkg::TempScale);
      hprod_q     <= 26'(job_i.humidity_word) * 26'(htfd_pkg::HumScale);
      s1_status_q <= job_i.frame_status;
    end
    if (s1_move) begin
      out_q.frame_status <= s1_status_q;
      if (s1_status_q == htfd_pkg::StatusOk) begin
        out_q.temperature_tenths <= $signed(tq - htfd_pkg::TempOffset);
        out_q.humidity_tenths    <= hq[9:0];
      end else begin
        out_q.temperature_tenths <= '0;
        out_q.humidity_tenths    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/humidity_temp_frame_decoder.sv @@
// top level of the humidity and temperature measurement frame decoder
//
// input channel (in_valid_i/in_ready_o/in_data_i): one frame byte per
// transaction, in the order temperature high, low, crc, humidity high, low, crc;
// frame_start forces the byte to be taken as the first of a new frame.
// output channel (out_valid_o/out_ready_i/out_data_o): one transaction per
// complete frame with temperature and humidity in tenths, or zeros and a
// nonzero status when a crc-8 check fails.
// throughput: one byte per cycle while the queue is not full; the front
// handles crc and framing for each byte as it is taken.
// after the sixth byte is taken, the job passes through the queue, the
// scale multiply register, then rounded division into the output register.
// a two-entry queue sits between front and back; when the receiver stalls the
// back holds its result and the queue fills, and in_ready_o drops only once
// the queue is full.
// reset clears frame position, crc state and all valid flags.
`default_nettype none
module humidity_temp_frame_decoder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  htfd_pkg::in_item_t      in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output htfd_pkg::out_item_t     out_data_o
);

  logic           push, full, pop, empty;
  htfd_pkg::job_t push_job, pop_job;

  htfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  htfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  htfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

@@ test/testbench.sv @@
// testbench for the humidity and temperature frame decoder: random byte streams, scoreboard check
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import htfd_pkg::*;

  localparam int HoldCycles = 400;
  localparam int DrainCycles = 12;
  localparam int IdleLimit = 5000;
  localparam int TotalBytes = 1550;

  class frame_scoreboard;
    localparam longint FullScale = 65535;

    logic [2:0]  position;
    logic [7:0]  crc;
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    bit          temp_good;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      position = PosTempHi;
      crc = CrcInit;
      temp_word = '0;
      hum_word = '0;
      temp_good = 1'b0;
      errors = 0;
    endfunction

    static function automatic logic [7:0] crc_feed(input logic [7:0] state,
                                                   input logic [7:0] value);
      logic [7:0] c;
      c = state ^ value;
      for (int i = 0; i < 8; i++) begin
        c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
      end
      return c;
    endfunction

    static function automatic logic [7:0] word_crc(input logic [15:0] word);
      return crc_feed(crc_feed(CrcInit, word[15:8]), word[7:0]);
    endfunction

    static function automatic longint round_scaled(input longint num);
      if (num >= 0) begin
        return (2 * num + FullScale) / (2 * FullScale);
      end
      return -((2 * (-num) + FullScale) / (2 * FullScale));
    endfunction

    function void note_byte(input in_item_t item);
      logic [2:0] pos;
      logic [7:0] value;
      bit         hum_good;
      longint     temp_val;
      longint     hum_val;
      out_item_t  res;
      value = item.frame_byte;
      if (item.frame_start || position > PosHumCrc) begin
        position = PosTempHi;
        crc = CrcInit;
      end
      pos = position;
      position = pos + 3'd1;
      case (pos)
        PosTempHi: begin
          crc = crc_feed(CrcInit, value);
          temp_word[15:8] = value;
        end
        PosTempLo: begin
          crc = crc_feed(crc, value);
          temp_word[7:0] = value;
        end
        PosTempCrc: begin
          temp_good = (crc == value);
          crc = CrcInit;
        end
        PosHumHi: begin
          crc = crc_feed(CrcInit, value);
          hum_word[15:8] = value;
        end
        PosHumLo: begin
          crc = crc_feed(crc, value);
          hum_word[7:0] = value;
        end
        default: begin
          hum_good = (crc == value);
          res = '0;
          if (!temp_good) begin
            res.frame_status = StatusTempCrc;
          end else if (!hum_good) begin
            res.frame_status = StatusHumCrc;
          end else begin
            temp_val = round_scaled(longint'(TempScale) * longint'(temp_word)
                                    - longint'(TempOffset) * FullScale);
            hum_val = round_scaled(longint'(HumScale) * longint'(hum_word));
            res.temperature_tenths = temp_val[11:0];
            res.humidity_tenths = hum_val[9:0];
            res.frame_status = StatusOk;
          end
          expected_q.push_back(res);
          crc = CrcInit;
          position = PosTempHi;
        end
      endcase
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: temperature_tenths %0d humidity_tenths %0d frame_status %0d",
               got.temperature_tenths, got.humidity_tenths, got.frame_status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.temperature_tenths !== want.temperature_tenths) begin
        $error("temperature_tenths: expected %0d, got %0d",
               want.temperature_tenths, got.temperature_tenths);
        errors++;
      end
      if (got.humidity_tenths !== want.humidity_tenths) begin
        $error("humidity_tenths: expected %0d, got %0d",
               want.humidity_tenths, got.humidity_tenths);
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  frame_scoreboard sb;
  int  bytes_sent = 0;
  int  idle_count = 0;
  bit  steady = 1'b0;
  bit  hold_rx = 1'b0;
  bit  rx_holding = 1'b0;
  bit  resync = 1'b1;

  humidity_temp_frame_decoder DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] random_word();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'h0000;
        1: return 16'h0001;
        2: return 16'hFFFE;
        3: return 16'h8000;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] value, input bit start);
    in_item_t item;
    int       gap;
    item.frame_byte = value;
    item.frame_start = start;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [15:0] temp_word, input logic [15:0] hum_word,
                            input bit start, input logic [7:0] temp_flip,
                            input logic [7:0] hum_flip);
    send_byte(temp_word[15:8], start);
    send_byte(temp_word[7:0], 1'b0);
    send_byte(frame_scoreboard::word_crc(temp_word) ^ temp_flip, 1'b0);
    send_byte(hum_word[15:8], 1'b0);
    send_byte(hum_word[7:0], 1'b0);
    send_byte(frame_scoreboard::word_crc(hum_word) ^ hum_flip, 1'b0);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic random_traffic(input int byte_limit);
    int  r;
    int  len;
    bit  start;
    while (bytes_sent < byte_limit) begin
      r = $urandom_range(0, 99);
      start = resync ? 1'b1 : 1'($urandom_range(0, 1));
      resync = 1'b0;
      if (r < 70) begin
        send_frame(random_word(), random_word(), start, 8'h00, 8'h00);
      end else if (r < 80) begin
        send_frame(random_word(), random_word(), start, 8'($urandom_range(1, 255)), 8'h00);
      end else if (r < 88) begin
        send_frame(random_word(), random_word(), start, 8'h00, 8'($urandom_range(1, 255)));
      end else if (r < 92) begin
        send_frame(random_word(), random_word(), start, 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
      end else if (r < 96) begin
        len = $urandom_range(1, 5);
        send_byte(8'($urandom), 1'b1);
        repeat (len - 1) send_byte(8'($urandom), 1'b0);
        resync = 1'b1;
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        resync = 1'b1;
      end
    end
  endtask

  // receiver
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx) begin
        rx_holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_rx = 1'b0;
        rx_holding = 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (in_valid && in_ready) sb.note_byte(in_data);
    if (out_valid && out_ready) sb.check_result(out_data);
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes of both words, back-to-back frames without start
    send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00);
    send_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00);
    // both crcs wrong
    send_frame(16'h6666, 16'h8000, 1'b1, 8'hFF, 8'h01);
    // start flag mid-frame, then humidity crc wrong
    send_byte(8'hAB, 1'b1);
    send_byte(8'hCD, 1'b0);
    send_frame(16'h1234, 16'hFEDC, 1'b1, 8'h00, 8'h80);

    random_traffic(700);

    // receiver holds off while the sender keeps pushing
    drain_results();
    hold_rx = 1'b1;
    while (!rx_holding) @(posedge clk);
    steady = 1'b1;
    repeat (8) send_frame(random_word(), random_word(), 1'b1, 8'h00, 8'h00);
    steady = 1'b0;
    drain_results();

    steady = 1'b1;
    random_traffic(bytes_sent + 200);
    steady = 1'b0;
    random_traffic(TotalBytes);

    drain_results();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
